@@ hdl/small_matrix_arithmetic_unit_assert.svh @@
// Assertion macros for the small matrix arithmetic unit.
// Included by smau_ctrl, which checks its own control sequencing.
`ifndef SMALL_MATRIX_ARITHMETIC_UNIT_ASSERT_SVH
`define SMALL_MATRIX_ARITHMETIC_UNIT_ASSERT_SVH

// same-cycle implication
`define SMAU_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("smau assertion failed");

// next-cycle implication
`define SMAU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("smau assertion failed");

`endif

@@ hdl/smau_pkg.sv @@
// Shared types, codes and defaults for the small matrix arithmetic unit.
// No dependencies; imported by every module of the block.
package smau_pkg;

	localparam int DIM_DEFAULT = 8;

	typedef enum logic [1:0] {
		CMD_LOAD_A  = 2'd0,
		CMD_LOAD_B  = 2'd1,
		CMD_COMPUTE = 2'd2
	} cmd_t;

	typedef enum logic [2:0] {
		OP_ADD       = 3'd0,
		OP_SUB       = 3'd1,
		OP_MUL       = 3'd2,
		OP_SCALE     = 3'd3,
		OP_TRANSPOSE = 3'd4
	} op_mode_t;

	typedef enum logic [2:0] {
		REG_OP_MODE      = 3'd0,
		REG_A_ROWS       = 3'd1,
		REG_A_COLS       = 3'd2,
		REG_B_COLS       = 3'd3,
		REG_SCALE_FACTOR = 3'd4
	} reg_index_t;

	typedef enum logic [2:0] {
		ST_IDLE  = 3'd0,
		ST_READ  = 3'd1,
		ST_MULT  = 3'd2,
		ST_ACCUM = 3'd3,
		ST_EMIT  = 3'd4
	} state_t;

	typedef struct packed {
		logic [2:0]         op_mode;
		logic [3:0]         a_rows;
		logic [3:0]         a_cols;
		logic [3:0]         b_cols;
		logic signed [31:0] scale_factor;
	} cfg_t;

	typedef struct packed {
		logic load;
		logic start;
		logic rd;
		logic mul;
		logic acc;
		logic step_k;
		logic out_load;
	} ctrl_cmd_t;

	typedef struct packed {
		logic k_last;
		logic mat_last;
		logic out_free;
	} ctrl_sts_t;

endpackage

@@ hdl/smau_cfg_regs.sv @@
// Configuration register file of the small matrix arithmetic unit.
// Depends on smau_pkg for the register index codes and cfg_t.
module smau_cfg_regs
	import smau_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data,
	output cfg_t        cfg
);

	cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.op_mode      <= OP_ADD;
			cfg_q.a_rows       <= 4'd1;
			cfg_q.a_cols       <= 4'd1;
			cfg_q.b_cols       <= 4'd1;
			cfg_q.scale_factor <= 32'sd1;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_OP_MODE:      cfg_q.op_mode      <= cfg_data[2:0];
				REG_A_ROWS:       cfg_q.a_rows       <= cfg_data[3:0];
				REG_A_COLS:       cfg_q.a_cols       <= cfg_data[3:0];
				REG_B_COLS:       cfg_q.b_cols       <= cfg_data[3:0];
				REG_SCALE_FACTOR: cfg_q.scale_factor <= cfg_data;
				default: ;
			endcase
		end
	end

endmodule

@@ hdl/smau_ctrl.sv @@
// Sequencing state machine of the small matrix arithmetic unit.
// Depends on smau_pkg and the assertion macro header.
`include "small_matrix_arithmetic_unit_assert.svh"

module smau_ctrl
	import smau_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [1:0] in_cmd,
	input  logic [2:0] op_mode,
	input  ctrl_sts_t  sts,
	output ctrl_cmd_t  cmd
);

	state_t state_q;
	state_t state_d;
	logic   op_ok;

	assign op_ok = (op_mode == OP_ADD) || (op_mode == OP_SUB) || (op_mode == OP_MUL) ||
		(op_mode == OP_SCALE) || (op_mode == OP_TRANSPOSE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid && in_cmd == CMD_COMPUTE && op_ok) state_d = ST_READ;
			end
			ST_READ:  state_d = ST_MULT;
			ST_MULT:  state_d = ST_ACCUM;
			ST_ACCUM: state_d = sts.k_last ? ST_EMIT : ST_READ;
			ST_EMIT: begin
				if (sts.out_free) state_d = sts.mat_last ? ST_IDLE : ST_READ;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready     = 1'b0;
		cmd          = '0;
		case (state_q)
			ST_IDLE: begin
				in_ready  = 1'b1;
				cmd.load  = in_valid;
				cmd.start = in_valid && in_cmd == CMD_COMPUTE && op_ok;
			end
			ST_READ:  cmd.rd = 1'b1;
			ST_MULT:  cmd.mul = 1'b1;
			ST_ACCUM: begin
				cmd.acc    = 1'b1;
				cmd.step_k = !sts.k_last;
			end
			ST_EMIT:  cmd.out_load = sts.out_free;
			default: ;
		endcase
	end

	`SMAU_ASSERT_SAME(a_load_needs_free, clk, arst_n, cmd.out_load, sts.out_free)
	`SMAU_ASSERT_NEXT(a_read_then_mul, clk, arst_n, cmd.rd, cmd.mul)
	`SMAU_ASSERT_NEXT(a_start_busy, clk, arst_n, cmd.start, !in_ready)

endmodule

@@ hdl/smau_datapath.sv @@
// Datapath of the small matrix arithmetic unit: matrix stores, index
// counters, multiply-accumulate and output register. Depends on smau_pkg.
module smau_datapath
	import smau_pkg::*;
#(
	parameter int DIM = DIM_DEFAULT
) (
	input  logic               clk,
	input  logic               arst_n,
	input  cfg_t               cfg,
	input  ctrl_cmd_t          ctl,
	output ctrl_sts_t          sts,
	input  logic [1:0]         in_cmd,
	input  logic [2:0]         elem_row,
	input  logic [2:0]         elem_col,
	input  logic signed [31:0] elem_value,
	input  logic               out_ready,
	output logic               out_valid,
	output logic [2:0]         out_row,
	output logic [2:0]         out_col,
	output logic signed [31:0] out_value,
	output logic               is_last
);

	localparam int DEPTH = DIM * DIM;
	localparam int AW    = $clog2(DEPTH);
	localparam int IW    = $clog2(DIM);
	localparam int DW    = $clog2(DIM + 1);

	function automatic logic [DW-1:0] clamp_dim(input logic [3:0] v);
		logic [DW-1:0] r;
		if (v == 4'd0) r = DW'(1);
		else if (32'(v) > DIM) r = DW'(DIM);
		else r = DW'(v);
		return r;
	endfunction

	function automatic logic [AW-1:0] elem_addr(input logic [AW-1:0] row,
		input logic [AW-1:0] col);
		return AW'(row * AW'(DIM) + col);
	endfunction

	logic [31:0]   mem_a [DEPTH];
	logic [31:0]   mem_b [DEPTH];

	logic [DW-1:0] rows, cols, bcols, nr, nc, nk;
	logic [IW-1:0] i_q, j_q, k_q;
	logic          i_last, j_last;
	logic [AW-1:0] ra_addr, rb_addr, ld_addr, wa_addr;
	logic          ld_ok, wa_en, wb_en;
	logic [31:0]   wa_data;
	logic [31:0]   rd_a_q, rd_b_q;
	logic [31:0]   op_b, prod, term, term_q, acc_q;
	logic          out_valid_q;
	logic [2:0]    out_row_q, out_col_q;
	logic [31:0]   out_value_q;
	logic          is_last_q;

	assign rows  = clamp_dim(cfg.a_rows);
	assign cols  = clamp_dim(cfg.a_cols);
	assign bcols = clamp_dim(cfg.b_cols);

	always_comb begin
		nr = rows;
		nc = cols;
		nk = DW'(1);
		case (cfg.op_mode)
			OP_MUL: begin
				nc = bcols;
				nk = cols;
			end
			OP_TRANSPOSE: begin
				nr = cols;
				nc = rows;
			end
			default: ;
		endcase
	end

	assign i_last       = (i_q == IW'(nr - DW'(1)));
	assign j_last       = (j_q == IW'(nc - DW'(1)));
	assign sts.k_last   = (k_q == IW'(nk - DW'(1)));
	assign sts.mat_last = i_last && j_last;
	assign sts.out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			i_q <= '0;
			j_q <= '0;
			k_q <= '0;
		end else if (ctl.start) begin
			i_q <= '0;
			j_q <= '0;
			k_q <= '0;
		end else if (ctl.step_k) begin
			k_q <= k_q + IW'(1);
		end else if (ctl.out_load) begin
			k_q <= '0;
			if (j_last) begin
				j_q <= '0;
				i_q <= i_q + IW'(1);
			end else begin
				j_q <= j_q + IW'(1);
			end
		end
	end

	always_comb begin
		ra_addr = elem_addr(AW'(i_q), AW'(j_q));
		rb_addr = elem_addr(AW'(i_q), AW'(j_q));
		case (cfg.op_mode)
			OP_MUL: begin
				ra_addr = elem_addr(AW'(i_q), AW'(k_q));
				rb_addr = elem_addr(AW'(k_q), AW'(j_q));
			end
			OP_TRANSPOSE: ra_addr = elem_addr(AW'(j_q), AW'(i_q));
			default: ;
		endcase
	end

	assign ld_ok   = (32'(elem_row) < DIM) && (32'(elem_col) < DIM);
	assign ld_addr = elem_addr(AW'(elem_row), AW'(elem_col));
	assign wa_en   = (ctl.load && ld_ok && in_cmd == CMD_LOAD_A) ||
		(ctl.out_load && cfg.op_mode == OP_SCALE);
	assign wa_addr = ctl.load ? ld_addr : elem_addr(AW'(i_q), AW'(j_q));
	assign wa_data = ctl.load ? elem_value : acc_q;
	assign wb_en   = ctl.load && ld_ok && in_cmd == CMD_LOAD_B;

	always_ff @(posedge clk) begin
		if (wa_en) mem_a[wa_addr] <= wa_data;
		if (ctl.rd) rd_a_q <= mem_a[ra_addr];
	end

	always_ff @(posedge clk) begin
		if (wb_en) mem_b[ld_addr] <= elem_value;
		if (ctl.rd) rd_b_q <= mem_b[rb_addr];
	end

	assign op_b = (cfg.op_mode == OP_SCALE) ? cfg.scale_factor : rd_b_q;
	assign prod = rd_a_q * op_b;

	always_comb begin
		case (cfg.op_mode)
			OP_ADD:   term = rd_a_q + rd_b_q;
			OP_SUB:   term = rd_a_q - rd_b_q;
			OP_MUL:   term = prod;
			OP_SCALE: term = prod;
			default:  term = rd_a_q;
		endcase
	end

	always_ff @(posedge clk) begin
		if (ctl.mul) term_q <= term;
		if (ctl.acc) acc_q <= ((k_q == '0) ? 32'd0 : acc_q) + term_q;
		if (ctl.out_load) begin
			out_row_q   <= 3'(i_q);
			out_col_q   <= 3'(j_q);
			out_value_q <= acc_q;
			is_last_q   <= sts.mat_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign out_row   = out_row_q;
	assign out_col   = out_col_q;
	assign out_value = out_value_q;
	assign is_last   = is_last_q;

endmodule

@@ hdl/small_matrix_arithmetic_unit.sv @@
// Load requests are accepted back to back while the block is idle, not during a compute.
// Compute: each result element steps through read, multiply and accumulate
// (repeated per a_cols term for multiply) and emit, one element at a time, as
// each store has a single registered read port and the MAC is shared.
// Reset clears sequencing and configuration; the stores hold no reset value.
// Depends on smau_pkg, smau_cfg_regs, smau_ctrl and smau_datapath.
module small_matrix_arithmetic_unit
	import smau_pkg::*;
#(
	parameter int DIM = DIM_DEFAULT
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [2:0]         cfg_index,
	input  logic [31:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         cmd,
	input  logic [2:0]         elem_row,
	input  logic [2:0]         elem_col,
	input  logic signed [31:0] elem_value,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [2:0]         out_row,
	output logic [2:0]         out_col,
	output logic signed [31:0] out_value,
	output logic               is_last
);

	cfg_t      cfg;
	ctrl_cmd_t ctl;
	ctrl_sts_t sts;

	smau_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	smau_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_cmd   (cmd),
		.op_mode  (cfg.op_mode),
		.sts      (sts),
		.cmd      (ctl)
	);

	smau_datapath #(
		.DIM (DIM)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.ctl        (ctl),
		.sts        (sts),
		.in_cmd     (cmd),
		.elem_row   (elem_row),
		.elem_col   (elem_col),
		.elem_value (elem_value),
		.out_ready  (out_ready),
		.out_valid  (out_valid),
		.out_row    (out_row),
		.out_col    (out_col),
		.out_value  (out_value),
		.is_last    (is_last)
	);

endmodule

@@ tb/sv/small_matrix_arithmetic_unit_test.sv @@
// Self-checking testbench for small_matrix_arithmetic_unit: loads A and B, runs every
// operation under directed and random settings, and checks each result element in order.
// Depends on smau_pkg and the block's RTL only.
module small_matrix_arithmetic_unit_test
	import smau_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int DIM = DIM_DEFAULT;
	localparam int SLOT_W = $clog2(DIM*DIM);
	localparam int SETTLE_CYCLES = 16;
	localparam logic [1:0] CMD_UNUSED = 2'd3;
	localparam logic [2:0] OP_RSVD_FIRST = 3'd5;
	localparam logic [2:0] OP_RSVD_LAST = 3'd7;

	typedef struct packed {
		logic [2:0]  row;
		logic [2:0]  col;
		logic [31:0] value;
		logic        last;
	} elem_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               cfg_valid = 1'b0;
	logic               cfg_ready;
	logic [2:0]         cfg_index = '0;
	logic [31:0]        cfg_data = '0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic [1:0]         cmd = '0;
	logic [2:0]         elem_row = '0;
	logic [2:0]         elem_col = '0;
	logic signed [31:0] elem_value = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic [2:0]         out_row;
	logic [2:0]         out_col;
	logic signed [31:0] out_value;
	logic               is_last;

	logic [31:0] mat_a [DIM*DIM];
	logic [31:0] mat_b [DIM*DIM];
	bit          a_known [DIM*DIM];
	bit          b_known [DIM*DIM];
	logic [2:0]  cur_op = OP_ADD;
	logic [3:0]  cur_rows = 4'd1;
	logic [3:0]  cur_cols = 4'd1;
	logic [3:0]  cur_bcols = 4'd1;
	logic [31:0] cur_scale = 32'd1;

	elem_t pending_elems [$];
	int    errors = 0;
	int    elems_checked = 0;
	int    items_sent = 0;
	int    cfg_writes = 0;
	int    op_count [8];
	int    send_idle_pct = 0;
	int    recv_stall_pct = 0;

	small_matrix_arithmetic_unit #(.DIM(DIM)) u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.cmd       (cmd),
		.elem_row  (elem_row),
		.elem_col  (elem_col),
		.elem_value(elem_value),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_row   (out_row),
		.out_col   (out_col),
		.out_value (out_value),
		.is_last   (is_last)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	always @(posedge clk) begin : check_results
		elem_t e;
		if (arst_n === 1'b1 && out_valid === 1'b1 && out_ready) begin
			if (pending_elems.size() == 0) begin
				$error("unexpected result: row %0d col %0d value %h", out_row, out_col, out_value);
				errors++;
			end else begin
				e = pending_elems.pop_front();
				elems_checked++;
				if (out_row !== e.row) begin
					$error("out_row: expected %0d, got %0d", e.row, out_row);
					errors++;
				end
				if (out_col !== e.col) begin
					$error("out_col: expected %0d, got %0d", e.col, out_col);
					errors++;
				end
				if (out_value !== e.value) begin
					$error("out_value: expected %h, got %h", e.value, out_value);
					errors++;
				end
				if (is_last !== e.last) begin
					$error("is_last: expected %0d, got %0d", e.last, is_last);
					errors++;
				end
			end
		end
	end

	function automatic logic [SLOT_W-1:0] slot(int r, int c);
		return SLOT_W'(r*DIM + c);
	endfunction

	function automatic int span(logic [3:0] v);
		if (v == 0)
			return 1;
		if (v > DIM)
			return DIM;
		return int'(v);
	endfunction

	function automatic logic [31:0] rand_value();
		case ($urandom_range(7))
		0: return 32'h8000_0000;
		1: return 32'h7FFF_FFFF;
		2: return 32'hFFFF_FFFF;
		3: return 32'h0000_0000;
		default: return $urandom();
		endcase
	endfunction

	function automatic logic [3:0] pick_dim();
		int roll;
		roll = $urandom_range(99);
		if (roll < 72)
			return 4'($urandom_range(3, 1));
		if (roll < 84)
			return 4'($urandom_range(DIM, 4));
		if (roll < 93)
			return 4'd0;
		return 4'($urandom_range(15, DIM + 1));
	endfunction

	function automatic void update_matrices(logic [1:0] c, logic [2:0] r, logic [2:0] col,
			logic [31:0] v);
		int rows, cols, bcols, nr, nc;
		logic [31:0] acc;
		elem_t e;
		rows = span(cur_rows);
		cols = span(cur_cols);
		bcols = span(cur_bcols);
		case (c)
		CMD_LOAD_A: begin
			mat_a[slot(r, col)] = v;
			a_known[slot(r, col)] = 1'b1;
		end
		CMD_LOAD_B: begin
			mat_b[slot(r, col)] = v;
			b_known[slot(r, col)] = 1'b1;
		end
		CMD_COMPUTE: begin
			op_count[cur_op]++;
			nr = (cur_op == OP_TRANSPOSE) ? cols : rows;
			nc = (cur_op == OP_MUL) ? bcols : (cur_op == OP_TRANSPOSE) ? rows : cols;
			if (cur_op > OP_TRANSPOSE)
				nr = 0;
			for (int i = 0; i < nr; i++) begin
				for (int j = 0; j < nc; j++) begin
					case (cur_op)
					OP_ADD: acc = mat_a[slot(i, j)] + mat_b[slot(i, j)];
					OP_SUB: acc = mat_a[slot(i, j)] - mat_b[slot(i, j)];
					OP_MUL: begin
						acc = '0;
						for (int k = 0; k < cols; k++)
							acc = acc + mat_a[slot(i, k)] * mat_b[slot(k, j)];
					end
					OP_SCALE: begin
						acc = mat_a[slot(i, j)] * cur_scale;
						mat_a[slot(i, j)] = acc;
					end
					default: acc = mat_a[slot(j, i)];
					endcase
					e.row = i[2:0];
					e.col = j[2:0];
					e.value = acc;
					e.last = (i == nr - 1) && (j == nc - 1);
					pending_elems.push_back(e);
				end
			end
		end
		default: ;
		endcase
	endfunction

	task automatic send_req(logic [1:0] c, logic [2:0] r, logic [2:0] col, logic [31:0] v);
		if ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
			while ($urandom_range(99) < send_idle_pct)
				@(posedge clk);
		end
		in_valid <= 1'b1;
		cmd <= c;
		elem_row <= r;
		elem_col <= col;
		elem_value <= v;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		update_matrices(c, r, col, v);
		if (c != CMD_UNUSED)
			items_sent++;
	endtask

	// hold requests until every result is out and the block has settled
	task automatic wait_idle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_elems.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(reg_index_t idx, logic [31:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		case (idx)
		REG_OP_MODE:      cur_op = data[2:0];
		REG_A_ROWS:       cur_rows = data[3:0];
		REG_A_COLS:       cur_cols = data[3:0];
		REG_B_COLS:       cur_bcols = data[3:0];
		REG_SCALE_FACTOR: cur_scale = data;
		default: ;
		endcase
		cfg_writes++;
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// load every operand entry the current setting reads that has not been written yet
	task automatic fill_operands();
		int rows, cols, brows, bcols;
		rows = span(cur_rows);
		cols = span(cur_cols);
		brows = 0;
		bcols = 0;
		if (cur_op > OP_TRANSPOSE)
			return;
		if (cur_op == OP_ADD || cur_op == OP_SUB) begin
			brows = rows;
			bcols = cols;
		end else if (cur_op == OP_MUL) begin
			brows = cols;
			bcols = span(cur_bcols);
		end
		for (int i = 0; i < rows; i++)
			for (int j = 0; j < cols; j++)
				if (!a_known[slot(i, j)])
					send_req(CMD_LOAD_A, i[2:0], j[2:0], rand_value());
		for (int i = 0; i < brows; i++)
			for (int j = 0; j < bcols; j++)
				if (!b_known[slot(i, j)])
					send_req(CMD_LOAD_B, i[2:0], j[2:0], rand_value());
	endtask

	task automatic send_compute();
		send_req(CMD_COMPUTE, 3'($urandom_range(7)), 3'($urandom_range(7)), $urandom());
	endtask

	task automatic random_config();
		logic [2:0] op;
		wait_idle();
		if ($urandom_range(99) < 88)
			op = 3'($urandom_range(OP_TRANSPOSE, OP_ADD));
		else
			op = 3'($urandom_range(OP_RSVD_LAST, OP_RSVD_FIRST));
		write_reg(REG_OP_MODE, 32'(op));
		write_reg(REG_A_ROWS, 32'(pick_dim()));
		write_reg(REG_A_COLS, 32'(pick_dim()));
		write_reg(REG_B_COLS, 32'(pick_dim()));
		write_reg(REG_SCALE_FACTOR, rand_value());
	endtask

	task automatic test_reset_config();
		send_req(CMD_LOAD_A, 3'd0, 3'd0, 32'h7FFF_FFFF);
		send_req(CMD_LOAD_B, 3'd0, 3'd0, 32'h0000_0001);
		send_compute();
		wait_idle();
	endtask

	task automatic test_each_operation();
		send_req(CMD_LOAD_A, 3'd0, 3'd1, 32'h8000_0000);
		send_req(CMD_LOAD_A, 3'd1, 3'd0, 32'hFFFF_FFFF);
		send_req(CMD_LOAD_A, 3'd1, 3'd1, 32'h0000_0001);
		send_req(CMD_LOAD_B, 3'd0, 3'd1, 32'h8000_0000);
		send_req(CMD_LOAD_B, 3'd1, 3'd0, 32'h7FFF_FFFF);
		send_req(CMD_LOAD_B, 3'd1, 3'd1, 32'hFFFF_FFFF);
		wait_idle();
		write_reg(REG_A_ROWS, 32'd2);
		write_reg(REG_A_COLS, 32'd2);
		write_reg(REG_B_COLS, 32'd2);
		write_reg(REG_SCALE_FACTOR, 32'hFFFF_FFFF);
		for (int o = OP_ADD; o <= OP_TRANSPOSE; o++) begin
			write_reg(REG_OP_MODE, o);
			send_compute();
			wait_idle();
		end
		write_reg(REG_SCALE_FACTOR, 32'h8000_0000);
		write_reg(REG_OP_MODE, 32'(OP_SCALE));
		send_compute();
		wait_idle();
	endtask

	task automatic test_dim_clamp();
		write_reg(REG_A_ROWS, 32'd0);
		write_reg(REG_A_COLS, 32'd15);
		write_reg(REG_B_COLS, 32'd0);
		write_reg(REG_OP_MODE, 32'(OP_TRANSPOSE));
		fill_operands();
		send_compute();
		wait_idle();
		write_reg(REG_OP_MODE, 32'(OP_MUL));
		fill_operands();
		send_compute();
		wait_idle();
		write_reg(REG_A_ROWS, 32'd15);
		write_reg(REG_A_COLS, 32'd0);
		write_reg(REG_B_COLS, 32'd15);
		fill_operands();
		send_compute();
		wait_idle();
	endtask

	task automatic test_unused_codes();
		write_reg(REG_OP_MODE, 32'(OP_RSVD_FIRST));
		send_compute();
		wait_idle();
		write_reg(REG_OP_MODE, 32'(OP_RSVD_LAST));
		send_compute();
		send_req(CMD_UNUSED, 3'($urandom_range(7)), 3'($urandom_range(7)), $urandom());
		wait_idle();
		write_reg(REG_OP_MODE, 32'(OP_ADD));
		write_reg(REG_A_ROWS, 32'd1);
		write_reg(REG_A_COLS, 32'd2);
		fill_operands();
		send_compute();
		wait_idle();
	endtask

	task automatic test_random_traffic(int gap_pct, int stall_pct, int n_items);
		int goal, roll;
		send_idle_pct = gap_pct;
		recv_stall_pct = stall_pct;
		goal = items_sent + n_items;
		while (items_sent < goal) begin
			if ($urandom_range(2) == 0)
				random_config();
			roll = $urandom_range(99);
			repeat ($urandom_range(3))
				send_req(2'($urandom_range(CMD_LOAD_B, CMD_LOAD_A)),
					3'($urandom_range(7)), 3'($urandom_range(7)), rand_value());
			if (roll < 12) begin
				send_req(CMD_UNUSED, 3'($urandom_range(7)), 3'($urandom_range(7)),
					$urandom());
			end else begin
				fill_operands();
				send_compute();
				if (roll > 80)
					send_compute();
			end
		end
		wait_idle();
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_config();
		test_each_operation();
		test_dim_clamp();
		test_unused_codes();
		test_random_traffic(0, 0, 45);
		test_random_traffic(74, 0, 45);
		test_random_traffic(0, 74, 45);
		test_random_traffic(29, 29, 45);
		send_idle_pct = 0;
		recv_stall_pct = 0;
		wait_idle();
		$display("Run covered %0d requests, %0d register writes, %0d result elements checked.",
			items_sent, cfg_writes, elems_checked);
		$display("Computes: add %0d, sub %0d, mul %0d, scale %0d, transpose %0d, reserved %0d.",
			op_count[OP_ADD], op_count[OP_SUB], op_count[OP_MUL], op_count[OP_SCALE],
			op_count[OP_TRANSPOSE], op_count[5] + op_count[6] + op_count[7]);
		if (errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

	initial begin
		#10_000_000;
		$display("Run timed out with %0d result elements outstanding.", pending_elems.size());
		$display("*** FAILED ***");
		$finish;
	end

endmodule
